### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tag lookup block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The expression holds at every clock edge outside reset.
`define CTL_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define CTL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define CTL_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define CTL_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/ctlwb_pkg.sv
// ----------------------------------------------------------------------------
// Tag lookup package
// Fixed field widths, register indexes and reset values of the settings.
// ----------------------------------------------------------------------------
package ctlwb_pkg;

   // Fixed widths of the settings and the result fields.
   localparam int CFG_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int SLOT_OUT_W = 8;
   localparam int TAG_OUT_W  = 16;
   localparam int MISS_W     = 32;

   typedef logic [CFG_W-1:0]     cfg_field_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   typedef logic [MISS_W-1:0]    miss_count_type;

   // Register indexes on the settings port.
   localparam csr_index_type REG_LINE_BITS   = 2'd0;
   localparam csr_index_type REG_SET_BITS    = 2'd1;
   localparam csr_index_type REG_OFFSET_BITS = 2'd2;

   // Reset values of the settings.
   localparam cfg_field_type LINE_BITS_RST   = 4'd4;
   localparam cfg_field_type SET_BITS_RST    = 4'd4;
   localparam cfg_field_type OFFSET_BITS_RST = 4'd3;

endpackage

### rtl/ctlwb_front.sv
// ----------------------------------------------------------------------------
// Tag lookup front end
// Holds the settings, splits each request address into tag and slot and
// flags bad settings, then hands the classified beat to the queue.
// ----------------------------------------------------------------------------
module ctlwb_front #(
   parameter int MAX_LINE_BITS = 8,
   parameter int ADDRESS_WIDTH = 16,
   parameter int ITEM_W        = 2 + MAX_LINE_BITS + ADDRESS_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   // Request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_action,
   input  logic [ADDRESS_WIDTH-1:0] req_address,
   // Settings port
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  ctlwb_pkg::csr_index_type csr_index,
   input  ctlwb_pkg::cfg_field_type csr_data,
   // Queue push side
   output logic                     push,
   output logic [ITEM_W-1:0]        push_item,
   input  logic                     queue_full
);

   localparam int EXT_W = (ADDRESS_WIDTH > MAX_LINE_BITS) ? ADDRESS_WIDTH : MAX_LINE_BITS;
   localparam logic [5:0] AW_LIM  = 6'(ADDRESS_WIDTH);
   localparam logic [3:0] MLB_LIM = 4'(MAX_LINE_BITS);

   typedef struct packed {
      logic                     write;
      logic                     bad;
      logic [MAX_LINE_BITS-1:0] slot;
      logic [ADDRESS_WIDTH-1:0] tag;
   } item_type;

   ctlwb_pkg::cfg_field_type line_bits_ff, line_bits_in;
   ctlwb_pkg::cfg_field_type set_bits_ff, set_bits_in;
   ctlwb_pkg::cfg_field_type offset_bits_ff, offset_bits_in;

   logic [EXT_W-1:0]         addr_ext;
   logic [EXT_W-1:0]         addr_shift;
   logic [MAX_LINE_BITS-1:0] line_mask;
   logic [MAX_LINE_BITS-1:0] set_mask;
   logic [MAX_LINE_BITS-1:0] line_no;
   logic [MAX_LINE_BITS-1:0] set_no;
   logic [MAX_LINE_BITS-1:0] in_set;
   logic [3:0]               span;
   logic [4:0]               tag_shift;
   logic [5:0]               field_sum;
   logic                     bad;
   item_type                 item;

   // Settings writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      line_bits_in   = line_bits_ff;
      set_bits_in    = set_bits_ff;
      offset_bits_in = offset_bits_ff;
      if (csr_valid) begin
         case (csr_index)
            ctlwb_pkg::REG_LINE_BITS:   line_bits_in   = csr_data;
            ctlwb_pkg::REG_SET_BITS:    set_bits_in    = csr_data;
            ctlwb_pkg::REG_OFFSET_BITS: offset_bits_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_bits_ff   <= ctlwb_pkg::LINE_BITS_RST;
         set_bits_ff    <= ctlwb_pkg::SET_BITS_RST;
         offset_bits_ff <= ctlwb_pkg::OFFSET_BITS_RST;
      end else begin
         line_bits_ff   <= line_bits_in;
         set_bits_ff    <= set_bits_in;
         offset_bits_ff <= offset_bits_in;
      end
   end

   // Settings check: sets fit the lines, lines fit the slots, fields fit the address.
   assign field_sum = 6'(line_bits_ff) + 6'(offset_bits_ff);
   assign bad = (set_bits_ff > line_bits_ff) || (line_bits_ff > MLB_LIM) ||
                (field_sum > AW_LIM);

   // Line number and tag from the address.
   assign addr_ext   = EXT_W'(req_address);
   assign addr_shift = addr_ext >> offset_bits_ff;
   assign line_mask  = ~({MAX_LINE_BITS{1'b1}} << line_bits_ff);
   assign line_no    = addr_shift[MAX_LINE_BITS-1:0] & line_mask;
   assign tag_shift  = 5'(line_bits_ff) + 5'(offset_bits_ff);

   // Slot: set bits go on top, the in-set bits below them.
   assign set_mask = ~({MAX_LINE_BITS{1'b1}} << set_bits_ff);
   assign set_no   = line_no & set_mask;
   assign in_set   = line_no >> set_bits_ff;
   assign span     = line_bits_ff - set_bits_ff;

   always_comb begin
      item.write = req_action;
      item.bad   = bad;
      item.slot  = (set_no << span) + in_set;
      item.tag   = req_address >> tag_shift;
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign push_item = item;

endmodule

### rtl/ctlwb_queue.sv
// ----------------------------------------------------------------------------
// Tag lookup queue
// Two-entry queue that decouples the front end from the lookup back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ctlwb_queue #(
   parameter int WIDTH = 26
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_item,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_item
);

   localparam logic [1:0] DEPTH = 2'd2;

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full       = (count_ff == DEPTH);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   `CTL_ASSERT_ALWAYS(a_no_overflow, clock, reset, !(push && full))
   `CTL_ASSERT_ALWAYS(a_no_underflow, clock, reset, !(pop && !head_valid))
   `CTL_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= DEPTH)
   `CTL_ASSERT_ALWAYS(a_ptr_count, clock, reset,
                      (count_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff))

endmodule

### rtl/ctlwb_back.sv
// ----------------------------------------------------------------------------
// Tag lookup back end
// Reads the tag memory, resolves hit or miss, updates the tag, valid and
// dirty marks and the miss count, and registers the result beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ctlwb_back #(
   parameter int MAX_LINE_BITS = 8,
   parameter int ADDRESS_WIDTH = 16,
   parameter int ITEM_W        = 2 + MAX_LINE_BITS + ADDRESS_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Queue pop side
   input  logic                                  head_valid,
   input  logic [ITEM_W-1:0]                     head_item,
   output logic                                  pop,
   // Result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_hit,
   output logic [ctlwb_pkg::SLOT_OUT_W-1:0]      rsp_slot_index,
   output logic [ctlwb_pkg::TAG_OUT_W-1:0]       rsp_stored_tag,
   output logic                                  rsp_dirty_after,
   output ctlwb_pkg::miss_count_type             rsp_miss_total,
   output logic                                  rsp_config_error
);

   localparam int SLOT_COUNT = 1 << MAX_LINE_BITS;

   typedef struct packed {
      logic                     write;
      logic                     bad;
      logic [MAX_LINE_BITS-1:0] slot;
      logic [ADDRESS_WIDTH-1:0] tag;
   } item_type;

   item_type head;

   // Line memory, each entry the dirty mark above the tag, and its
   // registered read port.
   logic [ADDRESS_WIDTH:0]   tag_mem [SLOT_COUNT];
   logic [ADDRESS_WIDTH:0]   rd_entry_ff;
   logic [ADDRESS_WIDTH:0]   fwd_entry_ff;
   logic                     fwd_ff;

   // Read stage.
   logic     rd_valid_ff, rd_valid_in;
   item_type rd_item_ff;

   // Valid marks and miss count.
   logic [SLOT_COUNT-1:0]     valid_ff, valid_in;
   ctlwb_pkg::miss_count_type miss_ff, miss_in;

   // Resolve stage.
   logic                     res_fire;
   logic                     rd_take;
   logic [ADDRESS_WIDTH:0]   held_entry;
   logic [ADDRESS_WIDTH-1:0] held_tag;
   logic                     held_dirty;
   logic                     hit;
   logic                     update;
   logic                     fill;
   logic                     dirty_new;
   logic [ADDRESS_WIDTH:0]   new_entry;
   logic [31:0]              slot_ext;
   logic [31:0]              tag_ext;

   // Result register.
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_hit_ff;
   logic [ctlwb_pkg::SLOT_OUT_W-1:0]     rsp_slot_ff;
   logic [ctlwb_pkg::TAG_OUT_W-1:0]      rsp_tag_ff;
   logic                                 rsp_dirty_ff;
   ctlwb_pkg::miss_count_type            rsp_miss_ff;
   logic                                 rsp_error_ff;

   assign head = head_item;

   // Handshake between the stages.
   assign res_fire = rd_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign rd_take  = !rd_valid_ff || res_fire;
   assign pop      = head_valid && rd_take;

   // Hit check with forwarding of a line update written during this beat's read.
   assign held_entry = fwd_ff ? fwd_entry_ff : rd_entry_ff;
   assign held_tag   = held_entry[ADDRESS_WIDTH-1:0];
   assign held_dirty = held_entry[ADDRESS_WIDTH];
   assign hit        = !rd_item_ff.bad && valid_ff[rd_item_ff.slot] &&
                       (held_tag == rd_item_ff.tag);
   assign update     = res_fire && !rd_item_ff.bad;
   assign fill       = update && !hit;
   assign dirty_new  = hit ? (held_dirty || rd_item_ff.write) : rd_item_ff.write;
   assign new_entry  = {dirty_new, rd_item_ff.tag};

   // Line memory: write on every good beat, read when a beat leaves the queue.
   always_ff @(posedge clock) begin
      if (update) begin
         tag_mem[rd_item_ff.slot] <= new_entry;
      end
      if (pop) begin
         rd_entry_ff  <= tag_mem[head.slot];
         fwd_ff       <= update && (rd_item_ff.slot == head.slot);
         fwd_entry_ff <= new_entry;
         rd_item_ff   <= head;
      end
   end

   // Read stage occupancy.
   assign rd_valid_in = rd_take ? head_valid : rd_valid_ff;

   // Valid marks and miss count update.
   always_comb begin
      valid_in = valid_ff;
      miss_in  = miss_ff;
      if (update) begin
         valid_in[rd_item_ff.slot] = 1'b1;
         if (!hit && (miss_ff != '1)) begin
            miss_in = miss_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         valid_ff    <= '0;
         miss_ff     <= '0;
      end else begin
         rd_valid_ff <= rd_valid_in;
         valid_ff    <= valid_in;
         miss_ff     <= miss_in;
      end
   end

   // Result beat.
   assign slot_ext = 32'(rd_item_ff.slot);
   assign tag_ext  = 32'(rd_item_ff.tag);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (res_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_fire) begin
         rsp_hit_ff   <= hit;
         rsp_miss_ff  <= miss_in;
         rsp_error_ff <= rd_item_ff.bad;
         if (rd_item_ff.bad) begin
            rsp_slot_ff  <= '0;
            rsp_tag_ff   <= '0;
            rsp_dirty_ff <= 1'b0;
         end else begin
            rsp_slot_ff  <= slot_ext[ctlwb_pkg::SLOT_OUT_W-1:0];
            rsp_tag_ff   <= tag_ext[ctlwb_pkg::TAG_OUT_W-1:0];
            rsp_dirty_ff <= dirty_new;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_slot_index   = rsp_slot_ff;
   assign rsp_stored_tag   = rsp_tag_ff;
   assign rsp_dirty_after  = rsp_dirty_ff;
   assign rsp_miss_total   = rsp_miss_ff;
   assign rsp_config_error = rsp_error_ff;

   `CTL_ASSERT_ALWAYS(a_write_sets_dirty, clock, reset, !(update && rd_item_ff.write && !dirty_new))
   `CTL_ASSERT_NEXT(a_miss_monotonic, clock, reset, 1'b1, miss_ff >= $past(miss_ff))
   `CTL_ASSERT_NEXT(a_fill_sets_valid, clock, reset, fill,
                    valid_ff[$past(rd_item_ff.slot)])
   `CTL_ASSERT_NEXT(a_bad_keeps_marks, clock, reset, res_fire && rd_item_ff.bad,
                    (valid_ff == $past(valid_ff)) && (miss_ff == $past(miss_ff)))
   `CTL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff)

endmodule

### rtl/cache_tag_lookup_write_back.sv
// A taken request beat goes through the queue, read stage and result register.
// Throughput: one access per cycle without rsp_stall; the line memory read is
// one registered stage, and a line update written in the same cycle is
// forwarded. Reset clears the settings to line 4, set 4, offset 3, clears all
// valid marks and the miss count at once, and empties the queue and stages;
// dirty marks sit beside the tags and are only read on a valid line.
// ----------------------------------------------------------------------------
// Write-back cache tag lookup
// Direct mapped or set-interleaved tag store with valid and dirty marks and a
// saturating miss count; a front end classifies accesses into a short queue.
// ----------------------------------------------------------------------------
module cache_tag_lookup_write_back #(
   parameter int MAX_LINE_BITS = 8,
   parameter int ADDRESS_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_action,
   input  logic [ADDRESS_WIDTH-1:0]              req_address,
   // Result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_hit,
   output logic [ctlwb_pkg::SLOT_OUT_W-1:0]      rsp_slot_index,
   output logic [ctlwb_pkg::TAG_OUT_W-1:0]       rsp_stored_tag,
   output logic                                  rsp_dirty_after,
   output ctlwb_pkg::miss_count_type             rsp_miss_total,
   output logic                                  rsp_config_error,
   // Settings port
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  ctlwb_pkg::csr_index_type              csr_index,
   input  ctlwb_pkg::cfg_field_type              csr_data
);

   localparam int ITEM_W = 2 + MAX_LINE_BITS + ADDRESS_WIDTH;

   logic              push;
   logic [ITEM_W-1:0] push_item;
   logic              queue_full;
   logic              pop;
   logic              head_valid;
   logic [ITEM_W-1:0] head_item;

   // Front end: settings and address split.
   ctlwb_front #(
      .MAX_LINE_BITS (MAX_LINE_BITS),
      .ADDRESS_WIDTH (ADDRESS_WIDTH),
      .ITEM_W        (ITEM_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_action  (req_action),
      .req_address (req_address),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .push        (push),
      .push_item   (push_item),
      .queue_full  (queue_full)
   );

   // Queue between the two halves.
   ctlwb_queue #(
      .WIDTH (ITEM_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // Back end: lookup, update and result register.
   ctlwb_back #(
      .MAX_LINE_BITS (MAX_LINE_BITS),
      .ADDRESS_WIDTH (ADDRESS_WIDTH),
      .ITEM_W        (ITEM_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_stored_tag   (rsp_stored_tag),
      .rsp_dirty_after  (rsp_dirty_after),
      .rsp_miss_total   (rsp_miss_total),
      .rsp_config_error (rsp_config_error)
   );

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Write-back cache tag lookup testbench
// Drives read and write accesses through several cache geometries, among them
// the legal extremes and illegal settings. A behavioral tag store in the bench
// predicts every result beat, and each beat is checked field by field.
// ----------------------------------------------------------------------------
module tb;

   localparam int ADDR_W     = 16;
   localparam int LINE_LIMIT = 8;
   localparam int SLOTS      = 1 << LINE_LIMIT;
   localparam int IDLE_PCT   = 37;

   // Index 3 is not decoded by the block, so writes to it must be dropped.
   localparam ctlwb_pkg::csr_index_type REG_UNUSED = 2'd3;

   localparam bit ACT_READ  = 1'b0;
   localparam bit ACT_WRITE = 1'b1;

   typedef struct packed {
      logic              action;
      logic [ADDR_W-1:0] address;
   } access_type;

   typedef struct packed {
      logic                             hit;
      logic [ctlwb_pkg::SLOT_OUT_W-1:0] slot;
      logic [ctlwb_pkg::TAG_OUT_W-1:0]  tag;
      logic                             dirty;
      ctlwb_pkg::miss_count_type        misses;
      logic                             bad_geometry;
   } lookup_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid   = 1'b0;
   logic              req_stall;
   logic              req_action  = 1'b0;
   logic [ADDR_W-1:0] req_address = '0;

   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic                             rsp_hit;
   logic [ctlwb_pkg::SLOT_OUT_W-1:0] rsp_slot_index;
   logic [ctlwb_pkg::TAG_OUT_W-1:0]  rsp_stored_tag;
   logic                             rsp_dirty_after;
   ctlwb_pkg::miss_count_type        rsp_miss_total;
   logic                             rsp_config_error;

   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   ctlwb_pkg::csr_index_type csr_index = '0;
   ctlwb_pkg::cfg_field_type csr_data  = '0;

   cache_tag_lookup_write_back dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_stored_tag   (rsp_stored_tag),
      .rsp_dirty_after  (rsp_dirty_after),
      .rsp_miss_total   (rsp_miss_total),
      .rsp_config_error (rsp_config_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // Bench copy of the geometry and of the tag store contents.
   int unsigned geo_line = ctlwb_pkg::LINE_BITS_RST;
   int unsigned geo_set  = ctlwb_pkg::SET_BITS_RST;
   int unsigned geo_off  = ctlwb_pkg::OFFSET_BITS_RST;

   logic [ctlwb_pkg::TAG_OUT_W-1:0] tag_mem [SLOTS];
   bit                              line_valid [SLOTS];
   bit                              line_dirty [SLOTS];
   ctlwb_pkg::miss_count_type       miss_count = '0;

   access_type pending_accesses[$];
   lookup_type expected_lookups[$];
   int         mismatch_count = 0;
   bit         no_gaps = 1'b0;

   function automatic int unsigned low_ones(int unsigned n);
      return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
   endfunction

   // Looks one access up in the bench tag store and updates it.
   function automatic lookup_type predict_lookup(access_type acc);
      int unsigned line_no;
      int unsigned tag_val;
      int unsigned set_no;
      int unsigned in_set;
      int unsigned slot;
      lookup_type  res;
      res        = '0;
      res.misses = miss_count;
      if (geo_set > geo_line || geo_line > LINE_LIMIT || geo_line + geo_off > ADDR_W) begin
         res.bad_geometry = 1'b1;
         return res;
      end
      line_no = (32'(acc.address) >> geo_off) & low_ones(geo_line);
      tag_val = 32'(acc.address) >> (geo_line + geo_off);
      set_no  = line_no & low_ones(geo_set);
      in_set  = line_no >> geo_set;
      slot    = ((set_no << (geo_line - geo_set)) + in_set) & (SLOTS - 1);
      res.hit = line_valid[slot] && (32'(tag_mem[slot]) == tag_val);
      if (res.hit) begin
         if (acc.action == ACT_WRITE) begin
            line_dirty[slot] = 1'b1;
         end
      end else begin
         tag_mem[slot]    = ctlwb_pkg::TAG_OUT_W'(tag_val);
         line_valid[slot] = 1'b1;
         line_dirty[slot] = (acc.action == ACT_WRITE);
         if (miss_count != 32'hFFFF_FFFF) begin
            miss_count = miss_count + 1;
         end
      end
      res.slot   = ctlwb_pkg::SLOT_OUT_W'(slot);
      res.tag    = tag_mem[slot];
      res.dirty  = line_dirty[slot];
      res.misses = miss_count;
      return res;
   endfunction

   // Clock and the single reset pulse at the start of the run.
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Request driver: offers queued accesses, with random gaps unless no_gaps is
   // set, and records the predicted result of every beat that the block takes.
   always @(posedge clock) begin : drive_requests
      access_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_lookups.push_back(predict_lookup({req_action, req_address}));
         end
         if (!req_valid || !req_stall) begin
            if (pending_accesses.size() > 0 &&
                (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
               nxt = pending_accesses.pop_front();
               req_valid   <= 1'b1;
               req_action  <= nxt.action;
               req_address <= nxt.address;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result receiver back-pressure.
   always @(posedge clock) begin : drive_result_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !no_gaps && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Result monitor: each taken beat is compared with the oldest prediction.
   always @(posedge clock) begin : check_results
      lookup_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_lookups.size() == 0) begin
            $error("result beat arrived with no access outstanding");
            mismatch_count++;
         end else begin
            want = expected_lookups.pop_front();
            check_field("rsp_hit", want.hit, rsp_hit);
            check_field("rsp_slot_index", want.slot, rsp_slot_index);
            check_field("rsp_stored_tag", want.tag, rsp_stored_tag);
            check_field("rsp_dirty_after", want.dirty, rsp_dirty_after);
            check_field("rsp_miss_total", want.misses, rsp_miss_total);
            check_field("rsp_config_error", want.bad_geometry, rsp_config_error);
         end
      end
   end

   // One register write beat; the bench geometry follows once it is taken.
   task automatic write_setting(ctlwb_pkg::csr_index_type idx,
                                ctlwb_pkg::cfg_field_type val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         ctlwb_pkg::REG_LINE_BITS: begin
            geo_line = val;
         end
         ctlwb_pkg::REG_SET_BITS: begin
            geo_set = val;
         end
         ctlwb_pkg::REG_OFFSET_BITS: begin
            geo_off = val;
         end
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   task automatic set_geometry(int unsigned line, int unsigned set, int unsigned off);
      write_setting(ctlwb_pkg::REG_LINE_BITS, ctlwb_pkg::CFG_W'(line));
      write_setting(ctlwb_pkg::REG_SET_BITS, ctlwb_pkg::CFG_W'(set));
      write_setting(ctlwb_pkg::REG_OFFSET_BITS, ctlwb_pkg::CFG_W'(off));
   endtask

   task automatic queue_access(logic action, logic [ADDR_W-1:0] address);
      pending_accesses.push_back({action, address});
   endtask

   // Waits until every access has been taken and answered, then lets the
   // two-stage pipeline drain. The check runs on the falling edge, once the
   // driver and monitor have settled for the cycle.
   task automatic wait_idle();
      @(negedge clock);
      while (pending_accesses.size() > 0 || expected_lookups.size() > 0 || req_valid) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Random accesses around a small working set so that hits, dirty lines and
   // conflicting tags come up often, with some fully random addresses.
   task automatic run_geometry(int unsigned line, int unsigned set, int unsigned off,
                               int count);
      logic [ADDR_W-1:0] working_set [8];
      logic [ADDR_W-1:0] addr;
      int unsigned       pick;
      int unsigned       index_mask;
      set_geometry(line, set, off);
      index_mask = low_ones(line + off);
      foreach (working_set[i]) working_set[i] = ADDR_W'($urandom);
      for (int n = 0; n < count; n++) begin
         addr = working_set[$urandom_range(0, 7)];
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            addr = addr ^ (ADDR_W'($urandom) & ADDR_W'(low_ones(off)));
         end else if (pick < 80) begin
            addr = (addr & ADDR_W'(index_mask)) | (ADDR_W'($urandom) & ~ADDR_W'(index_mask));
         end else begin
            addr = ADDR_W'($urandom);
         end
         queue_access(1'($urandom), addr);
      end
      wait_idle();
   endtask

   // Stimulus sequence and end of run.
   initial begin : stimulus
      @(negedge reset);
      @(posedge clock);

      // Reset geometry: miss, hits, write hit, read fill clearing dirty.
      queue_access(ACT_READ, 16'h0000);
      queue_access(ACT_READ, 16'h0005);
      queue_access(ACT_WRITE, 16'h0007);
      queue_access(ACT_READ, 16'h0000);
      queue_access(ACT_READ, 16'h0080);
      queue_access(ACT_WRITE, 16'h0100);
      queue_access(ACT_WRITE, 16'hFFFF);
      queue_access(ACT_READ, 16'hFFF8);
      wait_idle();

      // A write to the undecoded index leaves the geometry alone.
      write_setting(REG_UNUSED, 4'hF);
      queue_access(ACT_READ, 16'h0005);
      wait_idle();

      // Set-interleaved slots.
      set_geometry(8, 3, 4);
      queue_access(ACT_READ, 16'h0120);
      queue_access(ACT_WRITE, 16'h0124);
      wait_idle();

      // Empty tag, with the line field at the top of the address.
      set_geometry(1, 0, 15);
      queue_access(ACT_READ, 16'h8000);
      queue_access(ACT_WRITE, 16'h0000);
      wait_idle();
      set_geometry(8, 8, 8);
      queue_access(ACT_READ, 16'hAB00);
      queue_access(ACT_WRITE, 16'hABFF);
      wait_idle();

      // A single slot shared by every address.
      set_geometry(0, 0, 0);
      queue_access(ACT_READ, 16'h1234);
      queue_access(ACT_READ, 16'h1234);
      queue_access(ACT_WRITE, 16'h4321);
      wait_idle();

      // Illegal settings: too many line bits, sets above lines, fields too wide.
      set_geometry(9, 0, 0);
      queue_access(ACT_READ, 16'h5555);
      wait_idle();
      set_geometry(5, 6, 3);
      queue_access(ACT_WRITE, 16'hAAAA);
      wait_idle();
      set_geometry(8, 0, 9);
      queue_access(ACT_WRITE, 16'h0F0F);
      wait_idle();
      set_geometry(15, 15, 15);
      queue_access(ACT_READ, 16'hF0F0);
      wait_idle();

      // Random accesses over a spread of geometries; old lines stay valid
      // across every change of settings.
      run_geometry(4, 4, 3, 70);
      run_geometry(8, 8, 0, 70);
      no_gaps = 1'b1;
      run_geometry(8, 3, 4, 140);
      no_gaps = 1'b0;
      run_geometry(0, 0, 0, 40);
      run_geometry(1, 0, 15, 40);
      run_geometry(8, 8, 8, 60);
      run_geometry(6, 2, 10, 60);
      run_geometry(3, 1, 5, 60);
      run_geometry(8, 0, 8, 60);
      run_geometry(2, 2, 14, 40);
      run_geometry($urandom_range(0, 8), $urandom_range(0, 3), $urandom_range(0, 8), 60);
      run_geometry($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15), 30);
      run_geometry(12, 3, 2, 20);
      run_geometry(4, 4, 3, 60);

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_lookups.size() == 0) begin
         $display("cache_tag_lookup_write_back verification clean");
      end else begin
         $display("cache_tag_lookup_write_back verification failed");
      end
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin : run_limit
      #5ms;
      $display("cache_tag_lookup_write_back verification failed");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/ctlwb_pkg.sv
rtl/ctlwb_front.sv
rtl/ctlwb_queue.sv
rtl/ctlwb_back.sv
rtl/cache_tag_lookup_write_back.sv
verif/tb.sv
